// ===== hw/rtl/ppq_pkg.sv =====
// Shared constants, codes and types of the priority message queue.
package ppq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CHUNKS_PER_MESSAGE = 8;

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CH_IW = (CHUNKS_PER_MESSAGE > 1) ? $clog2(CHUNKS_PER_MESSAGE) : 1;
    localparam int CH_CW = $clog2(CHUNKS_PER_MESSAGE + 1);
    localparam int PAY_DEPTH = QUEUE_DEPTH * CHUNKS_PER_MESSAGE;
    localparam int PAY_AW = $clog2(PAY_DEPTH);
    localparam int MAX_LEN = (8 * CHUNKS_PER_MESSAGE < 64) ? 8 * CHUNKS_PER_MESSAGE : 64;
    localparam int DESC_W = 59;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] REG_MAX_RETRY_PRIORITY = 3'd0;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_RETRY   = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEN  = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NO_HELD  = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef struct packed {
        logic [3:0]  prio;
        logic [7:0]  ptype;
        logic [7:0]  dest;
        logic [6:0]  len;
        logic [31:0] tick;
    } desc_t;

endpackage

// ===== hw/rtl/ppq_in_if.sv =====
// Input channel of the priority message queue.
interface ppq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  priority_req;
    logic [7:0]  message_type;
    logic [7:0]  destination;
    logic [6:0]  message_length;
    logic [31:0] arrival_tick;
    logic [63:0] payload_chunk;
    logic        chunk_last;

    modport source (
        output valid, operation, priority_req, message_type, destination,
               message_length, arrival_tick, payload_chunk, chunk_last,
        input  ready
    );
    modport sink (
        input  valid, operation, priority_req, message_type, destination,
               message_length, arrival_tick, payload_chunk, chunk_last,
        output ready
    );
endinterface

// ===== hw/rtl/ppq_out_if.sv =====
// Result channel of the priority message queue.
interface ppq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  out_priority;
    logic [7:0]  out_message_type;
    logic [7:0]  out_destination;
    logic [6:0]  out_length;
    logic [31:0] out_tick;
    logic [63:0] out_chunk;
    logic        out_last;
    logic [4:0]  entry_count;
    logic [31:0] drop_count;
    logic [31:0] retry_count;
    logic [31:0] enqueued_count;

    modport source (
        output valid, status, out_priority, out_message_type, out_destination,
               out_length, out_tick, out_chunk, out_last, entry_count,
               drop_count, retry_count, enqueued_count,
        input  ready
    );
    modport sink (
        input  valid, status, out_priority, out_message_type, out_destination,
               out_length, out_tick, out_chunk, out_last, entry_count,
               drop_count, retry_count, enqueued_count,
        output ready
    );
endinterface

// ===== hw/rtl/priority_message_queue.sv =====
// Top level of the priority message queue: APB register port and queue sequencer.
// Staged chunks, rejected messages and empty cases show their result via the emit state.
// A stored message copies its staged chunks to the payload RAM, then walks the order list
// from the tail; a retry rewrites the descriptor and walks the same way. A dequeue shifts
// the order list and reads the descriptor, then shows one chunk per cycle while the receiver
// is ready. One item at a time; reset clears control state, free map and counters, not RAMs.
module priority_message_queue
    import ppq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    ppq_in_if.sink             in_ch,
    ppq_out_if.source          out_ch
);
    logic [3:0] max_retry_prio;

    ppq_apb u_apb (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .max_retry_prio (max_retry_prio)
    );

    ppq_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_retry_prio (max_retry_prio),
        .in_ch          (in_ch),
        .out_ch         (out_ch)
    );
endmodule

// ===== hw/rtl/ppq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ppq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/ppq_apb.sv =====
// APB configuration register file of the priority message queue.
module ppq_apb
    import ppq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [3:0]         max_retry_prio
);
    logic [3:0] max_retry_reg;
    logic [3:0] max_retry_next;

    assign pready = 1'b1;
    assign max_retry_prio = max_retry_reg;
    assign prdata = (paddr == REG_MAX_RETRY_PRIORITY) ? {28'd0, max_retry_reg} : 32'd0;

    always_comb
    begin
        max_retry_next = max_retry_reg;
        if (psel && penable && pwrite && (paddr == REG_MAX_RETRY_PRIORITY))
        begin
            max_retry_next = pwdata[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retry_reg <= 4'd15;
        end
        else
        begin
            max_retry_reg <= max_retry_next;
        end
    end
endmodule

// ===== hw/rtl/ppq_ctrl.sv =====
// Sequencer that keeps the order list, descriptors and payloads in RAMs.
module ppq_ctrl
    import ppq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] max_retry_prio,
    ppq_in_if.sink     in_ch,
    ppq_out_if.source  out_ch
);
    typedef enum logic [3:0] {
        S_IDLE, S_EMIT, S_COPY, S_INS, S_INS_ORD, S_INS_CMP, S_INS_END,
        S_DQ_HEAD, S_SH, S_SH_WR, S_DQ_DESC, S_DQ_CHUNK, S_RT_RD
    } state_t;

    state_t              state_reg, state_next;
    logic [63:0]         stage_reg [CHUNKS_PER_MESSAGE];
    logic [63:0]         stage_next [CHUNKS_PER_MESSAGE];
    logic [CH_CW-1:0]    stage_idx_reg, stage_idx_next;
    logic [QUEUE_DEPTH-1:0] free_reg, free_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SLOT_W-1:0]   held_slot_reg, held_slot_next;
    logic                held_valid_reg, held_valid_next;
    logic [31:0]         enq_total_reg, enq_total_next;
    logic [31:0]         drop_total_reg, drop_total_next;
    logic [31:0]         retry_total_reg, retry_total_next;
    logic [SLOT_W-1:0]   ins_slot_reg, ins_slot_next;
    logic [3:0]          ins_prio_reg, ins_prio_next;
    logic [CNT_W-1:0]    ins_idx_reg, ins_idx_next;
    logic [SLOT_W-1:0]   ord_val_reg, ord_val_next;
    op_t                 ret_op_reg, ret_op_next;
    logic [SLOT_W-1:0]   ord_ra_reg, ord_ra_next;
    logic [SLOT_W-1:0]   desc_ra_reg, desc_ra_next;
    logic [PAY_AW-1:0]   pay_ra_reg, pay_ra_next;
    logic [CH_CW-1:0]    copy_idx_reg, copy_idx_next;
    desc_t               hdr_reg, hdr_next;
    logic [CH_CW-1:0]    chunk_i_reg, chunk_i_next;
    logic [CH_CW-1:0]    nchunk_reg, nchunk_next;
    status_t             em_status_reg, em_status_next;
    logic                em_hdr_reg, em_hdr_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    desc_t               out_hdr_reg, out_hdr_next;
    logic [63:0]         out_chunk_reg, out_chunk_next;
    logic                out_last_reg, out_last_next;
    logic [CNT_W-1:0]    out_count_reg, out_count_next;
    logic [31:0]         out_drop_reg, out_drop_next;
    logic [31:0]         out_retry_reg, out_retry_next;
    logic [31:0]         out_enq_reg, out_enq_next;

    logic                ord_we;
    logic [SLOT_W-1:0]   ord_wa, ord_wd, ord_rdata;
    logic                desc_we;
    logic [SLOT_W-1:0]   desc_wa;
    desc_t               desc_wd;
    logic [DESC_W-1:0]   desc_rraw;
    desc_t               desc_rdata;
    logic                pay_we;
    logic [PAY_AW-1:0]   pay_wa;
    logic [63:0]         pay_wd, pay_rdata;

    logic                accept;
    logic                out_free;
    logic                any_free;
    logic [SLOT_W-1:0]   first_free;
    logic [4:0]          prio_inc;
    logic [6:0]          rem_bytes;
    logic [63:0]         masked_chunk;
    logic [7:0]          len_round;

    assign desc_rdata = desc_t'(desc_rraw);
    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept = in_ch.valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        any_free = 1'b0;
        first_free = '0;
        for (int s = QUEUE_DEPTH - 1; s >= 0; s--)
        begin
            if (free_reg[s])
            begin
                any_free = 1'b1;
                first_free = SLOT_W'(s);
            end
        end
    end

    // Bytes past the message length read as zero on the final chunk.
    always_comb
    begin
        rem_bytes = hdr_reg.len - {chunk_i_reg[3:0] & 4'hF, 3'b000};
        for (int b = 0; b < 8; b++)
        begin
            masked_chunk[8*b +: 8] = (7'(b) < rem_bytes) ? pay_rdata[8*b +: 8] : 8'd0;
        end
    end

    assign prio_inc = {1'b0, desc_rdata.prio} + 5'd1;
    assign len_round = {1'b0, desc_rdata.len} + 8'd7;

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        stage_idx_next = stage_idx_reg;
        free_next = free_reg;
        count_next = count_reg;
        held_slot_next = held_slot_reg;
        held_valid_next = held_valid_reg;
        enq_total_next = enq_total_reg;
        drop_total_next = drop_total_reg;
        retry_total_next = retry_total_reg;
        ins_slot_next = ins_slot_reg;
        ins_prio_next = ins_prio_reg;
        ins_idx_next = ins_idx_reg;
        ord_val_next = ord_val_reg;
        ret_op_next = ret_op_reg;
        ord_ra_next = ord_ra_reg;
        desc_ra_next = desc_ra_reg;
        pay_ra_next = pay_ra_reg;
        copy_idx_next = copy_idx_reg;
        hdr_next = hdr_reg;
        chunk_i_next = chunk_i_reg;
        nchunk_next = nchunk_reg;
        em_status_next = em_status_reg;
        em_hdr_next = em_hdr_reg;

        out_valid_next = out_ch.ready ? 1'b0 : out_valid_reg;
        out_status_next = out_status_reg;
        out_hdr_next = out_hdr_reg;
        out_chunk_next = out_chunk_reg;
        out_last_next = out_last_reg;
        out_count_next = out_count_reg;
        out_drop_next = out_drop_reg;
        out_retry_next = out_retry_reg;
        out_enq_next = out_enq_reg;

        ord_we = 1'b0;
        ord_wa = '0;
        ord_wd = '0;
        desc_we = 1'b0;
        desc_wa = '0;
        desc_wd = '0;
        pay_we = 1'b0;
        pay_wa = '0;
        pay_wd = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    em_hdr_next = 1'b0;
                    em_status_next = ST_OK;
                    state_next = S_EMIT;
                    case (op_t'(in_ch.operation))
                        OP_ENQUEUE:
                        begin
                            if (stage_idx_reg >= CH_CW'(CHUNKS_PER_MESSAGE))
                            begin
                                stage_idx_next = '0;
                                for (int k = 0; k < CHUNKS_PER_MESSAGE; k++)
                                begin
                                    stage_next[k] = '0;
                                end
                                em_status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                stage_next[stage_idx_reg[CH_IW-1:0]] = in_ch.payload_chunk;
                                stage_idx_next = stage_idx_reg + CH_CW'(1);
                                if (in_ch.chunk_last)
                                begin
                                    if (in_ch.message_length == 7'd0 ||
                                        in_ch.message_length > 7'(MAX_LEN) || !any_free)
                                    begin
                                        stage_idx_next = '0;
                                        for (int k = 0; k < CHUNKS_PER_MESSAGE; k++)
                                        begin
                                            stage_next[k] = '0;
                                        end
                                        if (in_ch.message_length == 7'd0 ||
                                            in_ch.message_length > 7'(MAX_LEN))
                                        begin
                                            em_status_next = ST_BAD_LEN;
                                        end
                                        else
                                        begin
                                            em_status_next = ST_FULL;
                                            drop_total_next = drop_total_reg + 32'd1;
                                        end
                                    end
                                    else
                                    begin
                                        free_next[first_free] = 1'b0;
                                        desc_we = 1'b1;
                                        desc_wa = first_free;
                                        desc_wd.prio = in_ch.priority_req;
                                        desc_wd.ptype = in_ch.message_type;
                                        desc_wd.dest = in_ch.destination;
                                        desc_wd.len = in_ch.message_length;
                                        desc_wd.tick = in_ch.arrival_tick;
                                        ins_slot_next = first_free;
                                        ins_prio_next = in_ch.priority_req;
                                        ins_idx_next = count_reg;
                                        copy_idx_next = '0;
                                        ret_op_next = OP_ENQUEUE;
                                        state_next = S_COPY;
                                    end
                                end
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                em_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // The previously held entry counts as sent.
                                if (held_valid_reg)
                                begin
                                    free_next[held_slot_reg] = 1'b1;
                                end
                                ord_ra_next = '0;
                                state_next = S_DQ_HEAD;
                            end
                        end
                        OP_RETRY:
                        begin
                            if (!held_valid_reg)
                            begin
                                em_status_next = ST_NO_HELD;
                            end
                            else
                            begin
                                desc_ra_next = held_slot_reg;
                                state_next = S_RT_RD;
                            end
                        end
                        default:
                        begin
                            em_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_status_next = em_status_reg;
                    out_hdr_next = em_hdr_reg ? hdr_reg : '0;
                    out_chunk_next = '0;
                    out_last_next = 1'b1;
                    out_count_next = count_reg;
                    out_drop_next = drop_total_reg;
                    out_retry_next = retry_total_reg;
                    out_enq_next = enq_total_reg;
                    state_next = S_IDLE;
                end
            end
            S_COPY:
            begin
                pay_we = 1'b1;
                pay_wa = PAY_AW'(ins_slot_reg) * PAY_AW'(CHUNKS_PER_MESSAGE)
                         + PAY_AW'(copy_idx_reg);
                pay_wd = stage_reg[copy_idx_reg[CH_IW-1:0]];
                if (copy_idx_reg == CH_CW'(CHUNKS_PER_MESSAGE - 1))
                begin
                    state_next = S_INS;
                end
                else
                begin
                    copy_idx_next = copy_idx_reg + CH_CW'(1);
                end
            end
            S_INS:
            begin
                // Walk from the tail, moving later-priority entries up by one.
                if (count_reg >= CNT_W'(QUEUE_DEPTH) || ins_idx_reg == '0)
                begin
                    if (count_reg < CNT_W'(QUEUE_DEPTH))
                    begin
                        ord_we = 1'b1;
                        ord_wa = '0;
                        ord_wd = ins_slot_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = S_INS_END;
                end
                else
                begin
                    ord_ra_next = SLOT_W'(ins_idx_reg - CNT_W'(1));
                    state_next = S_INS_ORD;
                end
            end
            S_INS_ORD:
            begin
                ord_val_next = ord_rdata;
                desc_ra_next = ord_rdata;
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                ord_we = 1'b1;
                ord_wa = ins_idx_reg[SLOT_W-1:0];
                if (desc_rdata.prio > ins_prio_reg)
                begin
                    ord_wd = ord_val_reg;
                    ins_idx_next = ins_idx_reg - CNT_W'(1);
                    state_next = S_INS;
                end
                else
                begin
                    ord_wd = ins_slot_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_INS_END;
                end
            end
            S_INS_END:
            begin
                em_status_next = ST_OK;
                state_next = S_EMIT;
                if (ret_op_reg == OP_RETRY)
                begin
                    retry_total_next = retry_total_reg + 32'd1;
                    em_hdr_next = 1'b1;
                end
                else
                begin
                    enq_total_next = enq_total_reg + 32'd1;
                    stage_idx_next = '0;
                    for (int k = 0; k < CHUNKS_PER_MESSAGE; k++)
                    begin
                        stage_next[k] = '0;
                    end
                end
            end
            S_DQ_HEAD:
            begin
                held_slot_next = ord_rdata;
                held_valid_next = 1'b1;
                desc_ra_next = ord_rdata;
                ins_idx_next = CNT_W'(1);
                state_next = S_SH;
            end
            S_SH:
            begin
                if (ins_idx_reg < count_reg)
                begin
                    ord_ra_next = ins_idx_reg[SLOT_W-1:0];
                    state_next = S_SH_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DQ_DESC;
                end
            end
            S_SH_WR:
            begin
                ord_we = 1'b1;
                ord_wa = SLOT_W'(ins_idx_reg - CNT_W'(1));
                ord_wd = ord_rdata;
                ins_idx_next = ins_idx_reg + CNT_W'(1);
                state_next = S_SH;
            end
            S_DQ_DESC:
            begin
                hdr_next = desc_rdata;
                nchunk_next = (len_round[7:3] > 5'(CHUNKS_PER_MESSAGE)) ?
                              CH_CW'(CHUNKS_PER_MESSAGE) : CH_CW'(len_round[7:3]);
                if (desc_rdata.len == 7'd0)
                begin
                    nchunk_next = CH_CW'(1);
                end
                chunk_i_next = '0;
                pay_ra_next = PAY_AW'(held_slot_reg) * PAY_AW'(CHUNKS_PER_MESSAGE);
                state_next = S_DQ_CHUNK;
            end
            S_DQ_CHUNK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_status_next = ST_OK;
                    out_hdr_next = hdr_reg;
                    out_chunk_next = masked_chunk;
                    out_last_next = (chunk_i_reg + CH_CW'(1) == nchunk_reg);
                    out_count_next = count_reg;
                    out_drop_next = drop_total_reg;
                    out_retry_next = retry_total_reg;
                    out_enq_next = enq_total_reg;
                    if (chunk_i_reg + CH_CW'(1) == nchunk_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        chunk_i_next = chunk_i_reg + CH_CW'(1);
                        pay_ra_next = pay_ra_reg + PAY_AW'(1);
                    end
                end
            end
            S_RT_RD:
            begin
                hdr_next = desc_rdata;
                hdr_next.prio = (prio_inc > {1'b0, max_retry_prio}) ?
                                max_retry_prio : prio_inc[3:0];
                desc_we = 1'b1;
                desc_wa = held_slot_reg;
                desc_wd = hdr_next;
                ins_slot_next = held_slot_reg;
                ins_prio_next = hdr_next.prio;
                ins_idx_next = count_reg;
                held_valid_next = 1'b0;
                ret_op_next = OP_RETRY;
                state_next = S_INS;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int k = 0; k < CHUNKS_PER_MESSAGE; k++)
            begin
                stage_reg[k] <= '0;
            end
            stage_idx_reg <= '0;
            free_reg <= '1;
            count_reg <= '0;
            held_slot_reg <= '0;
            held_valid_reg <= 1'b0;
            enq_total_reg <= '0;
            drop_total_reg <= '0;
            retry_total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            stage_idx_reg <= stage_idx_next;
            free_reg <= free_next;
            count_reg <= count_next;
            held_slot_reg <= held_slot_next;
            held_valid_reg <= held_valid_next;
            enq_total_reg <= enq_total_next;
            drop_total_reg <= drop_total_next;
            retry_total_reg <= retry_total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_slot_reg <= ins_slot_next;
        ins_prio_reg <= ins_prio_next;
        ins_idx_reg <= ins_idx_next;
        ord_val_reg <= ord_val_next;
        ret_op_reg <= ret_op_next;
        ord_ra_reg <= ord_ra_next;
        desc_ra_reg <= desc_ra_next;
        pay_ra_reg <= pay_ra_next;
        copy_idx_reg <= copy_idx_next;
        hdr_reg <= hdr_next;
        chunk_i_reg <= chunk_i_next;
        nchunk_reg <= nchunk_next;
        em_status_reg <= em_status_next;
        em_hdr_reg <= em_hdr_next;
        out_status_reg <= out_status_next;
        out_hdr_reg <= out_hdr_next;
        out_chunk_reg <= out_chunk_next;
        out_last_reg <= out_last_next;
        out_count_reg <= out_count_next;
        out_drop_reg <= out_drop_next;
        out_retry_reg <= out_retry_next;
        out_enq_reg <= out_enq_next;
    end

    // Read addresses come from the next-state values so data is ready in the cycle after.
    ppq_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_wa),
        .wdata (ord_wd),
        .raddr (ord_ra_next),
        .rdata (ord_rdata)
    );

    ppq_ram #(.WIDTH(DESC_W), .DEPTH(QUEUE_DEPTH)) u_desc_ram (
        .clk   (clk),
        .we    (desc_we),
        .waddr (desc_wa),
        .wdata (DESC_W'(desc_wd)),
        .raddr (desc_ra_next),
        .rdata (desc_rraw)
    );

    ppq_ram #(.WIDTH(64), .DEPTH(PAY_DEPTH)) u_payload_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_wa),
        .wdata (pay_wd),
        .raddr (pay_ra_next),
        .rdata (pay_rdata)
    );

    assign out_ch.valid = out_valid_reg;
    assign out_ch.status = out_status_reg;
    assign out_ch.out_priority = out_hdr_reg.prio;
    assign out_ch.out_message_type = out_hdr_reg.ptype;
    assign out_ch.out_destination = out_hdr_reg.dest;
    assign out_ch.out_length = out_hdr_reg.len;
    assign out_ch.out_tick = out_hdr_reg.tick;
    assign out_ch.out_chunk = out_chunk_reg;
    assign out_ch.out_last = out_last_reg;
    assign out_ch.entry_count = 5'(out_count_reg);
    assign out_ch.drop_count = out_drop_reg;
    assign out_ch.retry_count = out_retry_reg;
    assign out_ch.enqueued_count = out_enq_reg;
endmodule

// ===== tb/sv/tb_priority_message_queue.sv =====
// Testbench of the priority message queue: directed and random transactions checked against a predictor.
module tb_priority_message_queue;
    import ppq_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  prio;
        logic [7:0]  ptype;
        logic [7:0]  dest;
        logic [6:0]  len;
        logic [31:0] tick;
        logic [63:0] chunk;
        logic        last;
        logic [4:0]  count;
        logic [31:0] drops;
        logic [31:0] retries;
        logic [31:0] enqueued;
    } result_t;

    localparam int STALL_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    ppq_in_if in_ch();
    ppq_out_if out_ch();

    priority_message_queue u_top (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    // Predictor state.
    logic [3:0]  retry_ceiling;
    logic [3:0]  order_q [QUEUE_DEPTH];
    desc_t       slot_desc [QUEUE_DEPTH];
    logic [63:0] slot_payload [QUEUE_DEPTH][CHUNKS_PER_MESSAGE];
    logic [QUEUE_DEPTH-1:0] free_map;
    int          queued;
    int          staged;
    logic [63:0] staging [CHUNKS_PER_MESSAGE];
    int          held_slot;
    bit          holding;
    logic [31:0] enq_total;
    logic [31:0] drop_total;
    logic [31:0] retry_total;

    result_t expected_q[$];
    int  errors;
    int  idle_cycles;
    bit  random_stall;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic result_t make_result(logic [2:0] st, bit has_desc, desc_t d,
                                            logic [63:0] ch, bit last);
        result_t r;
        r = '0;
        r.status = st;
        if (has_desc)
        begin
            r.prio = d.prio;
            r.ptype = d.ptype;
            r.dest = d.dest;
            r.len = d.len;
            r.tick = d.tick;
        end
        r.chunk = ch;
        r.last = last;
        r.count = queued[4:0];
        r.drops = drop_total;
        r.retries = retry_total;
        r.enqueued = enq_total;
        return r;
    endfunction

    function automatic void sorted_insert(int slot);
        int pos;
        pos = queued;
        for (int i = 0; i < queued; i++)
        begin
            if (slot_desc[order_q[i]].prio > slot_desc[slot].prio)
            begin
                pos = i;
                break;
            end
        end
        if (queued >= QUEUE_DEPTH)
            return;
        for (int i = queued; i > pos; i--)
            order_q[i] = order_q[i - 1];
        order_q[pos] = slot[3:0];
        queued++;
    endfunction

    function automatic void clear_staging();
        staged = 0;
        for (int i = 0; i < CHUNKS_PER_MESSAGE; i++)
            staging[i] = '0;
    endfunction

    // Works out the results of one transaction and queues them.
    function automatic void predict_queue_op(logic [1:0] op, logic [3:0] pr, logic [7:0] pt,
                                             logic [7:0] ds, logic [6:0] ln, logic [31:0] tk,
                                             logic [63:0] ch, logic cl);
        desc_t d;
        int slot;
        int n;
        int blen;
        logic [63:0] c;
        d = '0;
        case (op)
            OP_ENQUEUE:
            begin
                if (staged >= CHUNKS_PER_MESSAGE)
                begin
                    clear_staging();
                    expected_q.push_back(make_result(ST_OVERFLOW, 0, d, '0, 1));
                end
                else
                begin
                    staging[staged] = ch;
                    staged++;
                    if (!cl)
                        expected_q.push_back(make_result(ST_OK, 0, d, '0, 1));
                    else if (ln == 0 || ln > MAX_LEN)
                    begin
                        clear_staging();
                        expected_q.push_back(make_result(ST_BAD_LEN, 0, d, '0, 1));
                    end
                    else
                    begin
                        slot = -1;
                        for (int s = 0; s < QUEUE_DEPTH; s++)
                            if (free_map[s] && slot < 0)
                                slot = s;
                        if (slot < 0)
                        begin
                            drop_total++;
                            clear_staging();
                            expected_q.push_back(make_result(ST_FULL, 0, d, '0, 1));
                        end
                        else
                        begin
                            free_map[slot] = 1'b0;
                            slot_desc[slot] = '{prio: pr, ptype: pt, dest: ds, len: ln,
                                                tick: tk};
                            for (int i = 0; i < CHUNKS_PER_MESSAGE; i++)
                                slot_payload[slot][i] = staging[i];
                            sorted_insert(slot);
                            enq_total++;
                            clear_staging();
                            expected_q.push_back(make_result(ST_OK, 0, d, '0, 1));
                        end
                    end
                end
            end
            OP_DEQUEUE:
            begin
                if (queued == 0)
                    expected_q.push_back(make_result(ST_EMPTY, 0, d, '0, 1));
                else
                begin
                    if (holding)
                        free_map[held_slot] = 1'b1;
                    slot = order_q[0];
                    for (int i = 1; i < queued; i++)
                        order_q[i - 1] = order_q[i];
                    queued--;
                    held_slot = slot;
                    holding = 1;
                    d = slot_desc[slot];
                    blen = d.len;
                    n = (blen + 7) / 8;
                    for (int i = 0; i < n; i++)
                    begin
                        c = slot_payload[slot][i];
                        if (blen - 8 * i < 8)
                            c &= (64'd1 << (8 * (blen - 8 * i))) - 64'd1;
                        expected_q.push_back(make_result(ST_OK, 1, d, c, i == n - 1));
                    end
                end
            end
            OP_RETRY:
            begin
                if (!holding)
                    expected_q.push_back(make_result(ST_NO_HELD, 0, d, '0, 1));
                else
                begin
                    if (slot_desc[held_slot].prio + 5'd1 > retry_ceiling)
                        slot_desc[held_slot].prio = retry_ceiling;
                    else
                        slot_desc[held_slot].prio = slot_desc[held_slot].prio + 4'd1;
                    holding = 0;
                    sorted_insert(held_slot);
                    retry_total++;
                    expected_q.push_back(make_result(ST_OK, 1, slot_desc[held_slot], '0, 1));
                end
            end
            default:
                expected_q.push_back(make_result(ST_OK, 0, d, '0, 1));
        endcase
    endfunction

    // Result checker and receiver stalls.
    initial
    begin
        int wait_left;
        result_t got;
        result_t want;
        out_ch.ready = 1'b0;
        wait_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.status, out_ch.out_priority, out_ch.out_message_type,
                        out_ch.out_destination, out_ch.out_length, out_ch.out_tick,
                        out_ch.out_chunk, out_ch.out_last, out_ch.entry_count,
                        out_ch.drop_count, out_ch.retry_count, out_ch.enqueued_count};
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, want, got);
                        errors++;
                    end
                end
                wait_left = random_stall ? $urandom_range(0, 7) : 0;
            end
            if (wait_left > 0)
            begin
                wait_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: counts cycles with no transaction on either channel.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Valid stays high after an accept so that a following item can go out back to back;
    // the idle gap or the drain lowers it.
    task automatic send_item(logic [1:0] op, logic [3:0] pr, logic [7:0] pt, logic [7:0] ds,
                             logic [6:0] ln, logic [31:0] tk, logic [63:0] ch, logic cl);
        int gap;
        gap = random_stall ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.priority_req <= pr;
        in_ch.message_type <= pt;
        in_ch.destination <= ds;
        in_ch.message_length <= ln;
        in_ch.arrival_tick <= tk;
        in_ch.payload_chunk <= ch;
        in_ch.chunk_last <= cl;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_queue_op(op, pr, pt, ds, ln, tk, ch, cl);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Sends a whole message of the given chunk count with random content.
    task automatic send_message(int chunks, logic [3:0] pr, logic [6:0] ln);
        for (int i = 0; i < chunks; i++)
            send_item(OP_ENQUEUE, pr, 8'($urandom()), 8'($urandom()), ln, $urandom(),
                      rand64(), i == chunks - 1);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_ceiling(logic [3:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_MAX_RETRY_PRIORITY;
        pwdata <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        retry_ceiling = value;
    endtask

    task automatic test_directed();
        send_item(OP_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_RETRY, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_NOP, 4'hf, 8'hff, 8'hff, 7'h7f, '1, '1, 1);
        send_message(1, 4'd0, 7'd0);
        send_message(1, 4'd3, 7'd65);
        send_message(1, 4'd3, 7'd127);
        send_message(8, 4'hf, 7'd64);
        send_message(1, 4'd0, 7'd1);
        send_message(2, 4'd0, 7'd3);
        send_message(1, 4'd5, 7'd20);
        send_message(3, 4'd5, 7'd8);
        for (int i = 0; i < 6; i++)
            send_item(OP_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_RETRY, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_RETRY, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 9; i++)
            send_item(OP_ENQUEUE, 4'd1, 0, 0, 7'd9, 0, rand64(), 0);
        drain_results();
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            send_message(1, 4'($urandom_range(0, 15)), 7'($urandom_range(1, 8)));
        send_item(OP_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);
        send_message(1, 4'd2, 7'd8);
        send_item(OP_RETRY, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < QUEUE_DEPTH + 1; i++)
            send_item(OP_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);
        drain_results();
    endtask

    task automatic test_random(int count);
        int sent;
        int pick;
        int chunks;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                chunks = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 3);
                send_message(chunks, 4'($urandom()),
                             ($urandom_range(0, 9) == 0) ? 7'($urandom())
                                                          : 7'($urandom_range(1, 24)));
                sent += chunks;
            end
            else
            begin
                if (pick < 70)
                    send_item(OP_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);
                else if (pick < 88)
                    send_item(OP_RETRY, 0, 0, 0, 0, 0, 0, 0);
                else
                    send_item(2'($urandom()), 4'($urandom()), 8'($urandom()),
                              8'($urandom()), 7'($urandom()), $urandom(), rand64(),
                              1'($urandom()));
                sent++;
            end
            if (pick == 50)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        random_stall = 0;
        retry_ceiling = 4'd15;
        for (int s = 0; s < QUEUE_DEPTH; s++)
        begin
            order_q[s] = '0;
            slot_desc[s] = '0;
            for (int i = 0; i < CHUNKS_PER_MESSAGE; i++)
                slot_payload[s][i] = '0;
        end
        free_map = '1;
        queued = 0;
        clear_staging();
        held_slot = 0;
        holding = 0;
        enq_total = '0;
        drop_total = '0;
        retry_total = '0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_NOP;
        in_ch.priority_req = '0;
        in_ch.message_type = '0;
        in_ch.destination = '0;
        in_ch.message_length = '0;
        in_ch.arrival_tick = '0;
        in_ch.payload_chunk = '0;
        in_ch.chunk_last = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        random_stall = 1;
        write_ceiling(4'd0);
        test_full_queue();
        write_ceiling(4'd7);
        test_random(30);
        write_ceiling(4'd15);
        test_random(25);
        random_stall = 0;
        test_random(10);
        random_stall = 1;
        write_ceiling(4'd0);
        test_random(20);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ppq_pkg.sv
hw/rtl/ppq_in_if.sv
hw/rtl/ppq_out_if.sv
hw/rtl/ppq_ram.sv
hw/rtl/ppq_apb.sv
hw/rtl/ppq_ctrl.sv
hw/rtl/priority_message_queue.sv
tb/sv/tb_priority_message_queue.sv
